>>> rtl/core/stdc_pkg.sv
`timescale 1ns / 1ps

package stdc_pkg;

    // Field widths
    localparam int LEVEL_W  = 15;
    localparam int BUTTON_W = 14;
    localparam int RSUM_W   = 16;   // button + cv without overflow
    localparam int NUM_TRIG = 8;

    // Level fed to an unpatched stage whose predecessor is clear (10 V)
    localparam logic signed [LEVEL_W-1:0] FULL_MV = 15'sd10000;

    // Register indexes on the configuration port
    localparam logic CFG_HIGH_THR = 1'b0;
    localparam logic CFG_LOW_THR  = 1'b1;

    localparam logic signed [LEVEL_W-1:0] HIGH_THR_RESET = 15'sd1000;
    localparam logic signed [LEVEL_W-1:0] LOW_THR_RESET  = 15'sd0;

    typedef enum logic [1:0] {
        Q_UNKNOWN = 2'd0,
        Q_LOW     = 2'd1,
        Q_HIGH    = 2'd2
    } qual_t;

    typedef struct packed {
        qual_t q_next;
        logic  rise;
    } qual_res_t;

endpackage

>>> rtl/core/stdc_schmitt.sv
`timescale 1ns / 1ps

module stdc_schmitt
    import stdc_pkg::*;
#(
    parameter int LEVEL_BITS = 15
)
(
    input  logic signed [LEVEL_BITS-1:0] level,
    input  logic signed [LEVEL_W-1:0]    high_thr,
    input  logic signed [LEVEL_W-1:0]    low_thr,
    input  qual_t                        q,
    output qual_res_t                    res
);

    logic signed [LEVEL_BITS-1:0] high_ext;
    logic signed [LEVEL_BITS-1:0] low_ext;
    logic                         at_high;
    logic                         at_low;

    assign high_ext = LEVEL_BITS'(high_thr);
    assign low_ext  = LEVEL_BITS'(low_thr);
    assign at_high  = (level >= high_ext);
    assign at_low   = (level <= low_ext);

    // from the unknown state the high test wins when both thresholds are met
    always_comb
    begin
        res.q_next = q;
        res.rise   = 1'b0;
        unique case (q)
            Q_LOW:
            begin
                if (at_high)
                begin
                    res.q_next = Q_HIGH;
                    res.rise   = 1'b1;
                end
            end
            Q_HIGH:
            begin
                if (at_low)
                begin
                    res.q_next = Q_LOW;
                end
            end
            default:
            begin
                if (at_high)
                begin
                    res.q_next = Q_HIGH;
                end
                else if (at_low)
                begin
                    res.q_next = Q_LOW;
                end
                else
                begin
                    res.q_next = Q_UNKNOWN;
                end
            end
        endcase
    end

endmodule

>>> rtl/core/schmitt_toggle_divider_chain_core.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  ---------------------------------------------
// in       in_valid / in_ready    trig_level_1..8, patched_mask,
//                                 reset_button_mv, reset_cv_mv
// out      out_valid / out_ready  stage_bits
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; a taken beat passes from
// the input register through one qualify/toggle pass into the result register.
// The chain state is updated in the same cycle the result register loads, so the
// following beat already sees it.
// Reset: toggles cleared, all qualifiers unknown, thresholds 1000 mV / 0 mV.
// Stalls: in_ready falls only while the input register is full and the result
// waits on out_ready. cfg_ready is always high.

module schmitt_toggle_divider_chain_core
    import stdc_pkg::*;
#(
    parameter int STAGES = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [LEVEL_W-1:0]   trig_level_1,
    input  logic signed [LEVEL_W-1:0]   trig_level_2,
    input  logic signed [LEVEL_W-1:0]   trig_level_3,
    input  logic signed [LEVEL_W-1:0]   trig_level_4,
    input  logic signed [LEVEL_W-1:0]   trig_level_5,
    input  logic signed [LEVEL_W-1:0]   trig_level_6,
    input  logic signed [LEVEL_W-1:0]   trig_level_7,
    input  logic signed [LEVEL_W-1:0]   trig_level_8,
    input  logic [NUM_TRIG-1:0]         patched_mask,
    input  logic [BUTTON_W-1:0]         reset_button_mv,
    input  logic signed [LEVEL_W-1:0]   reset_cv_mv,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NUM_TRIG-1:0]         stage_bits,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic signed [LEVEL_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [LEVEL_W-1:0] high_thr_reg;
    logic signed [LEVEL_W-1:0] low_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HIGH_THR: high_thr_reg <= cfg_data;
                CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                default:      high_thr_reg <= high_thr_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds result register
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register (no reset, qualified by in_valid_reg)
    logic signed [LEVEL_W-1:0] trig_reg [NUM_TRIG];
    logic [NUM_TRIG-1:0]       mask_reg;
    logic [BUTTON_W-1:0]       button_reg;
    logic signed [LEVEL_W-1:0] cv_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            trig_reg[0] <= trig_level_1;
            trig_reg[1] <= trig_level_2;
            trig_reg[2] <= trig_level_3;
            trig_reg[3] <= trig_level_4;
            trig_reg[4] <= trig_level_5;
            trig_reg[5] <= trig_level_6;
            trig_reg[6] <= trig_level_7;
            trig_reg[7] <= trig_level_8;
            mask_reg    <= patched_mask;
            button_reg  <= reset_button_mv;
            cv_reg      <= reset_cv_mv;
        end
    end

    // ------------------------------------------------------------------
    // Chain state
    // ------------------------------------------------------------------
    logic [STAGES-1:0] toggle_reg;
    logic [STAGES-1:0] toggle_next;
    qual_t             qual_reg  [STAGES];
    qual_t             qual_next [STAGES];
    qual_t             rst_qual_reg;
    qual_res_t         rst_res;
    logic signed [RSUM_W-1:0] rsum;
    logic [NUM_TRIG-1:0] bits_next;
    logic [NUM_TRIG-1:0] stage_bits_reg;

    // reset sum: button is unsigned, widened before the add
    assign rsum = $signed({{(RSUM_W-BUTTON_W){1'b0}}, button_reg}) + RSUM_W'(cv_reg);

    stdc_schmitt #(
        .LEVEL_BITS (RSUM_W)
    ) u_rst_qual (
        .level    (rsum),
        .high_thr (high_thr_reg),
        .low_thr  (low_thr_reg),
        .q        (rst_qual_reg),
        .res      (rst_res)
    );

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            logic signed [LEVEL_W-1:0] level;
            qual_res_t                 res;

            // unpatched stage sees the inverted previous output of its neighbour; stage 0 always takes trig_level_1
            if (i == 0)
            begin : g_first
                assign level = trig_reg[0];
            end
            else
            begin : g_rest
                assign level = mask_reg[i] ? trig_reg[i]
                             : (toggle_reg[i-1] ? '0 : FULL_MV);
            end

            stdc_schmitt #(
                .LEVEL_BITS (LEVEL_W)
            ) u_qual (
                .level    (level),
                .high_thr (high_thr_reg),
                .low_thr  (low_thr_reg),
                .q        (qual_reg[i]),
                .res      (res)
            );

            // reset edge overrides any toggle in the same sample
            assign toggle_next[i] = rst_res.rise ? 1'b0 : (toggle_reg[i] ^ res.rise);
            assign qual_next[i]   = rst_res.rise ? Q_UNKNOWN : res.q_next;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    toggle_reg[i] <= 1'b0;
                    qual_reg[i]   <= Q_UNKNOWN;
                end
                else if (advance)
                begin
                    toggle_reg[i] <= toggle_next[i];
                    qual_reg[i]   <= qual_next[i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        bits_next = '0;
        bits_next[STAGES-1:0] = toggle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_qual_reg <= Q_UNKNOWN;
        end
        else if (advance)
        begin
            rst_qual_reg <= rst_res.q_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_bits_reg <= bits_next;
        end
    end

    assign stage_bits = stage_bits_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (stage_bits_reg[STAGES-1:0] == toggle_reg))
        else $error("result does not match chain state");

    a_reset_edge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && rst_res.rise) |=> (toggle_reg == '0 && qual_reg[0] == Q_UNKNOWN))
        else $error("reset edge did not clear the chain");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat produced no result");

endmodule
